// File: rtl/sha1_pkg.sv
// Shared constants, types and functions of the SHA-1 digest block.
`default_nettype none

package sha1_pkg;

    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CHAIN_AW  = 3;
    localparam int unsigned ROUNDS    = 80;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned LEN_W     = 64;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h6745_2301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h1032_5476;
    localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2_E1F0;

    localparam logic [WORD_W-1:0] K_ROUND0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K_ROUND1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K_ROUND2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K_ROUND3 = 32'hCA62_C1D6;

    localparam logic [7:0]       PAD_MARK = 8'h80;
    localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
    localparam logic [POS_W-1:0] LAST_POS = 6'd63;
    localparam logic [CHAIN_AW-1:0] LAST_IDX = 3'd4;

    typedef struct packed {
        logic             load;
        logic             round;
        logic             rot;
        logic             push;
        logic             word_end;
        logic [CNT_W-1:0] t;
        logic [7:0]       data;
    } t_rnd_ctl;

    function automatic logic [WORD_W-1:0] h_init(input logic [CHAIN_AW-1:0] idx);
        logic [WORD_W-1:0] v;
        unique case (idx)
            3'd0:    v = H0_INIT;
            3'd1:    v = H1_INIT;
            3'd2:    v = H2_INIT;
            3'd3:    v = H3_INIT;
            default: v = H4_INIT;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sha1_chain_mem.sv
// Chaining-value memory with one registered read port and per-entry valid bits.
`default_nettype none

module sha1_chain_mem (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_rd,
    input  wire logic [sha1_pkg::CHAIN_AW-1:0]    i_raddr,
    output logic      [sha1_pkg::WORD_W-1:0]      o_rdata,
    input  wire logic                             i_we,
    input  wire logic [sha1_pkg::CHAIN_AW-1:0]    i_waddr,
    input  wire logic [sha1_pkg::WORD_W-1:0]      i_wdata,
    input  wire logic                             i_clr
);
    import sha1_pkg::*;

    logic [WORD_W-1:0]    r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_W-1:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : h_init(i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/sha1_round.sv
// Byte packing, message schedule shift line and the working variables a to e.
`default_nettype none

module sha1_round (
    input  wire logic                        i_clk,
    input  wire sha1_pkg::t_rnd_ctl          i_ctl,
    input  wire logic [sha1_pkg::WORD_W-1:0] i_ldata,
    output logic      [sha1_pkg::WORD_W-1:0] o_a
);
    import sha1_pkg::*;

    logic [WORD_W-1:0] r_w [16];
    logic [23:0]       r_acc;
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [WORD_W-1:0] w_x, w_cur, f_v, k_v, tmp;

    always_comb begin
        w_x   = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_cur = (i_ctl.t < 7'd16) ? r_w[0] : {w_x[WORD_W-2:0], w_x[WORD_W-1]};
        if (i_ctl.t < 7'd20) begin
            f_v = (r_b & r_c) | (~r_b & r_d);
            k_v = K_ROUND0;
        end else if (i_ctl.t < 7'd40) begin
            f_v = r_b ^ r_c ^ r_d;
            k_v = K_ROUND1;
        end else if (i_ctl.t < 7'd60) begin
            f_v = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_v = K_ROUND2;
        end else begin
            f_v = r_b ^ r_c ^ r_d;
            k_v = K_ROUND3;
        end
        tmp = {r_a[WORD_W-6:0], r_a[WORD_W-1:WORD_W-5]} + f_v + r_e + w_cur + k_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_acc <= {r_acc[15:0], i_ctl.data};
        end
        if (i_ctl.push && i_ctl.word_end) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= {r_acc, i_ctl.data};
        end else if (i_ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= i_ldata;
        end else if (i_ctl.rot) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= r_a;
        end else if (i_ctl.round) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[WORD_W-1:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    assign o_a = r_a;

endmodule

`default_nettype wire

// File: rtl/sha1_message_digest.sv
// Top level of the streaming SHA-1 digest block: sequencer, padding and output register.
//
//  Channel   Direction  tdata                 tuser            tlast
//  s_axis    in         data_byte[7:0]        byte_valid       last_item
//  m_axis    out        digest_word[31:0]     word_index[2:0]  last_word
//
// A message byte is taken while the sequencer is idle. Each full 64-byte block then
// holds the input while a..e are loaded from the chain memory, the 80 rounds run and
// a..e are added back. A last item triggers one padding byte per cycle, one or two
// blocks, and five digest transactions, each read and captured through the single chain
// memory read port. Reset is synchronous and active low and needs no clearing pass.
// A stalled output holds its word and the sequencer; only while the last word waits is
// the next message accepted.
`default_nettype none

module sha1_message_digest (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte[7:0]
    input  wire logic [0:0]  s_axis_tuser,  // byte_valid[0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // digest_word[31:0]
    output logic [2:0]       m_axis_tuser,  // word_index[2:0]
    output logic             m_axis_tlast
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OWR   = 3'd6;

    logic [2:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [POS_W-1:0]    r_pos;
    logic [LEN_W-1:0]    r_len;
    logic                r_pad, r_mark, r_inlen;
    logic [CHAIN_AW-1:0] r_oidx;
    logic                r_ovld, r_olast;
    logic [WORD_W-1:0]   r_odata;
    logic [CHAIN_AW-1:0] r_otag;

    logic                in_acc, out_acc;
    logic                put_en;
    logic [7:0]          put_byte, pad_byte;
    logic [LEN_W-1:0]    len_sh;
    logic [POS_W-1:0]    pos_inc;
    t_rnd_ctl            rnd_ctl;
    logic                mem_rd, mem_we, mem_clr;
    logic [CHAIN_AW-1:0] mem_raddr, mem_waddr;
    logic [WORD_W-1:0]   mem_rdata, mem_wdata, var_a;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = r_ovld && m_axis_tready;
    assign pos_inc       = r_pos + 6'd1;

    always_comb begin
        len_sh   = r_len >> {~r_pos[2:0], 3'b000};
        pad_byte = r_mark ? PAD_MARK : (r_inlen ? len_sh[7:0] : 8'h00);
        put_en   = (in_acc && s_axis_tuser[0]) || (r_state == S_PAD);
        put_byte = (r_state == S_PAD) ? pad_byte : s_axis_tdata;
    end

    always_comb begin
        rnd_ctl.load     = (r_state == S_LOAD) && (r_cnt != '0);
        rnd_ctl.round    = (r_state == S_ROUND);
        rnd_ctl.rot      = (r_state == S_FIN) && (r_cnt != '0);
        rnd_ctl.push     = put_en;
        rnd_ctl.word_end = (r_pos[1:0] == 2'd3);
        rnd_ctl.t        = r_cnt;
        rnd_ctl.data     = put_byte;
    end

    always_comb begin
        mem_rd    = 1'b0;
        mem_raddr = r_cnt[CHAIN_AW-1:0];
        if ((r_state == S_LOAD || r_state == S_FIN) && r_cnt < 7'd5) begin
            mem_rd = 1'b1;
        end else if (r_state == S_ORD && (!r_ovld || out_acc)) begin
            mem_rd    = 1'b1;
            mem_raddr = r_oidx;
        end
        mem_we    = rnd_ctl.rot;
        mem_waddr = r_cnt[CHAIN_AW-1:0] - 3'd1;
        mem_wdata = mem_rdata + var_a;
        mem_clr   = (r_state == S_OWR) && (r_oidx == LAST_IDX);
    end

    sha1_chain_mem u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (mem_rd),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_clr   (mem_clr)
    );

    sha1_round u_round (
        .i_clk   (i_clk),
        .i_ctl   (rnd_ctl),
        .i_ldata (mem_rdata),
        .o_a     (var_a)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pos   <= '0;
            r_len   <= '0;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_inlen <= 1'b0;
            r_oidx  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (out_acc) begin
                r_ovld <= 1'b0;
            end
            if (put_en) begin
                r_pos <= pos_inc;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser[0]) begin
                            r_len <= r_len + 64'd8;
                        end
                        if (s_axis_tlast) begin
                            r_pad  <= 1'b1;
                            r_mark <= 1'b1;
                        end
                        r_cnt <= '0;
                        if (put_en && r_pos == LAST_POS) begin
                            r_state <= S_LOAD;
                        end else if (s_axis_tlast) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_mark <= 1'b0;
                    if (pos_inc == LEN_POS) begin
                        r_inlen <= 1'b1;
                    end
                    r_cnt <= '0;
                    if (r_pos == LAST_POS) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (r_cnt == 7'd5) begin
                        r_cnt   <= '0;
                        r_state <= S_ROUND;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ROUND: begin
                    if (r_cnt == 7'(ROUNDS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_FIN: begin
                    if (r_cnt == 7'd5) begin
                        r_cnt  <= '0;
                        r_oidx <= '0;
                        if (!r_pad) begin
                            r_state <= S_IDLE;
                        end else if (r_inlen) begin
                            r_state <= S_ORD;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ORD: begin
                    if (mem_rd) begin
                        r_state <= S_OWR;
                    end
                end
                S_OWR: begin
                    r_ovld <= 1'b1;
                    if (r_oidx == LAST_IDX) begin
                        r_len   <= '0;
                        r_pad   <= 1'b0;
                        r_inlen <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_oidx  <= r_oidx + 3'd1;
                        r_state <= S_ORD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OWR) begin
            r_odata <= mem_rdata;
            r_otag  <= r_oidx;
            r_olast <= (r_oidx == LAST_IDX);
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_otag;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_IDX)))
        else $error("Digest tlast does not match the word index.");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OWR) |-> (!r_ovld || out_acc))
        else $error("Digest word overwrites a pending output transaction.");

    a_len_in_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inlen |-> r_pad)
        else $error("Length bytes are selected outside of padding.");

    a_no_clr_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_clr))
        else $error("Chain memory written while its valid bits are cleared.");

    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE || r_state == S_PAD) && $past(r_state) == S_FIN) |-> r_pos == '0)
        else $error("Compression ended with a partial block position.");
`endif

endmodule

`default_nettype wire

// File: verif/sha1_digest_checker.sv
// Checker for the SHA-1 digest block: predicts digest words from accepted bytes and compares.
`default_nettype none

module sha1_digest_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,  // data_byte[7:0]
    input  wire logic [0:0]  i_s_tuser,  // byte_valid[0]
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,  // digest_word[31:0]
    input  wire logic [2:0]  i_m_tuser,  // word_index[2:0]
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_digests_pending
);

    import sha1_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        final_word;
    } t_digest_word;

    logic [31:0]  chain [5];
    logic [7:0]   block_bytes [64];
    int           block_fill;
    logic [63:0]  msg_bits;
    t_digest_word digest_q [$];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain[0] = H0_INIT;
        chain[1] = H1_INIT;
        chain[2] = H2_INIT;
        chain[3] = H3_INIT;
        chain[4] = H4_INIT;
        msg_bits = '0;
        block_fill = 0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, sum;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
        end
        for (t = 16; t < 80; t++) begin
            w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            sum = rotl(a, 5) + f + e + w[t] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function automatic void absorb_octet(input logic [7:0] octet);
        block_bytes[block_fill] = octet;
        block_fill++;
        if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    function automatic void close_message();
        logic [63:0]  len;
        t_digest_word exp_w;
        int i;
        len = msg_bits;
        absorb_octet(PAD_MARK);
        while (block_fill != int'(LEN_POS)) begin
            absorb_octet(8'h00);
        end
        for (i = 7; i >= 0; i--) begin
            absorb_octet(len[8*i +: 8]);
        end
        for (i = 0; i < 5; i++) begin
            exp_w.word = chain[i];
            exp_w.index = 3'(i);
            exp_w.final_word = (i == 4);
            digest_q = {digest_q, exp_w};
        end
        restart_chain();
    endfunction

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        t_digest_word got_w;
        if (!i_rst_n) begin
            restart_chain();
            digest_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0]) begin
                    absorb_octet(i_s_tdata);
                    msg_bits += 64'd8;
                end
                if (i_s_tlast) begin
                    close_message();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got_w.word = i_m_tdata;
                got_w.index = i_m_tuser;
                got_w.final_word = i_m_tlast;
                if (digest_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX) begin
                        $display("unexpected digest transaction: word %h index %0d last %b",
                                 got_w.word, got_w.index, got_w.final_word);
                    end
                end else begin
                    exp_w = digest_q.pop_front();
                    if (got_w.word !== exp_w.word || got_w.index !== exp_w.index ||
                        got_w.final_word !== exp_w.final_word) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX) begin
                            $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                     exp_w.word, exp_w.index, exp_w.final_word,
                                     got_w.word, got_w.index, got_w.final_word);
                        end
                    end
                end
            end
        end
        o_digests_pending = digest_q.size();
    end

endmodule

`default_nettype wire

// File: verif/sha1_message_digest_tb.sv
// Testbench top for the SHA-1 digest block: clock, reset, byte stimulus, output stalls, verdict.
`default_nettype none

module sha1_message_digest_tb;

    localparam int ITEMS        = 210;
    localparam int CALM_FROM    = 170;
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int   fail_count;
    int   digests_pending;
    int   item_cnt = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   pad_lengths [6] = '{55, 56, 57, 63, 64, 65};

    always #5 i_clk = ~i_clk;

    sha1_message_digest u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sha1_digest_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_axis_tvalid),
        .i_s_tready        (s_axis_tready),
        .i_s_tdata         (s_axis_tdata),
        .i_s_tuser         (s_axis_tuser),
        .i_s_tlast         (s_axis_tlast),
        .i_m_tvalid        (m_axis_tvalid),
        .i_m_tready        (m_axis_tready),
        .i_m_tdata         (m_axis_tdata),
        .i_m_tuser         (m_axis_tuser),
        .i_m_tlast         (m_axis_tlast),
        .o_fail_count      (fail_count),
        .o_digests_pending (digests_pending)
    );

    task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= has_byte;
        s_axis_tlast <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        item_cnt++;
        calm = (item_cnt >= CALM_FROM);
    endtask

    task automatic send_message(input int n_bytes, input logic byte_on_last);
        int i;
        int body;
        body = (n_bytes > 0 && byte_on_last) ? n_bytes - 1 : n_bytes;
        for (i = 0; i < body; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), n_bytes > 0 && byte_on_last, 1'b1);
    endtask

    initial begin
        int hold_cnt;
        logic hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
                    @(negedge i_clk);
                end
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int pick;
        int n_bytes;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, then one-byte messages at both byte extremes.
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // Byte-less items inside a message, and a last transaction that carries no byte.
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'hA5, 1'b1, 1'b1);

        hold_req = 1'b1;
        while (item_cnt < ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                n_bytes = $urandom_range(0, 6);
            end else if (pick < 8) begin
                n_bytes = pad_lengths[$urandom_range(0, 5)];
            end else begin
                n_bytes = $urandom_range(0, 70);
            end
            if (n_bytes > ITEMS - item_cnt) begin
                n_bytes = ITEMS - item_cnt;
            end
            send_message(n_bytes, 1'($urandom_range(0, 1)));
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (digests_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
